>>> rtl/wlfs_pkg.sv
`default_nettype none

package wlfs_pkg;

   localparam int SENSOR_BITS_DEF    = 16;
   localparam int STOP_CROSSINGS_DEF = 2;

   localparam int NUM_SENSORS = 6;
   localparam int RAW_W       = 16;
   localparam int LVL_W       = 9;
   localparam int SLOW_W      = 18;
   localparam int MULT_W      = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LVL_W-1:0]  FULL_LEVEL = 9'd256;
   localparam logic [SLOW_W-1:0] PCT_ONE    = 18'd25600;

   // Shared restoring divider: the quotient always fits in DIV_Q_W bits here.
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_Q_W   = 9;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   // Sensor slots in the queue entry.
   localparam logic [2:0] SLOT_LEFT_OUTER  = 3'd0;
   localparam logic [2:0] SLOT_LEFT_MIDDLE = 3'd1;
   localparam logic [2:0] SLOT_LEFT_INNER  = 3'd2;
   localparam logic [2:0] SLOT_RIGHT_INNER = 3'd3;
   localparam logic [2:0] SLOT_RIGHT_MIDDLE = 3'd4;
   localparam logic [2:0] SLOT_RIGHT_OUTER = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPEED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_FLOOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_CEILING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_LEVEL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_WEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_WEIGHT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_WEIGHT  = 3'd7;

   typedef struct packed {
      logic [7:0]       drive_speed;
      logic [RAW_W-1:0] raw_floor;
      logic [RAW_W-1:0] raw_ceiling;
      logic [LVL_W-1:0] white_level;
      logic [LVL_W-1:0] black_level;
      logic [7:0]       inner_weight;
      logic [7:0]       middle_weight;
      logic [7:0]       outer_weight;
   } cfg_type;

   typedef struct packed {
      logic [7:0] left_drive;
      logic [7:0] right_drive;
      logic       left_reverse;
      logic       right_reverse;
      logic       motors_halted;
      logic       over_line;
      logic [1:0] crossings;
   } result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quo;
   } div_rsp_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SCALE,
      B_DIV,
      B_ACC,
      B_MOTOR,
      B_PROD,
      B_RATIO,
      B_RWAIT,
      B_DONE
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/wlfs_front.sv
`default_nettype none

module wlfs_front #(
   parameter int SENSOR_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [wlfs_pkg::NUM_SENSORS-1:0][SENSOR_BITS-1:0] req_raw,
   input  logic                                         pop,
   output logic                                         q_valid,
   output logic [wlfs_pkg::NUM_SENSORS-1:0][SENSOR_BITS-1:0] q_raw
);
   import wlfs_pkg::*;

   logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_raw     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (pop && q_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !(pop && q_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop && q_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_raw;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wlfs_div.sv
`default_nettype none

module wlfs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wlfs_pkg::div_req_type div_req,
   output wlfs_pkg::div_rsp_type div_rsp
);
   import wlfs_pkg::*;

   localparam int DSH_W = DIV_DEN_W + DIV_Q_W - 1;

   logic [DIV_NUM_W-1:0] rem_ff;
   logic [DSH_W-1:0]     dsh_ff;
   logic [DIV_Q_W-1:0]   quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 fits;

   assign fits = (DSH_W'(rem_ff) >= dsh_ff);

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // One quotient bit per cycle, most significant first.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.num;
         dsh_ff <= {div_req.den, {(DIV_Q_W-1){1'b0}}};
         quo_ff <= '0;
         cnt_ff <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - DIV_NUM_W'(dsh_ff);
         end
         quo_ff <= {quo_ff[DIV_Q_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

>>> rtl/wlfs_back.sv
`default_nettype none

module wlfs_back #(
   parameter int SENSOR_BITS    = 16,
   parameter int STOP_CROSSINGS = 2
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  wlfs_pkg::cfg_type                                 cfg,
   input  logic                                              q_valid,
   input  logic [wlfs_pkg::NUM_SENSORS-1:0][SENSOR_BITS-1:0] q_raw,
   output logic                                              pop,
   output wlfs_pkg::div_req_type                             div_req,
   input  wlfs_pkg::div_rsp_type                             div_rsp,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output wlfs_pkg::result_type                              result
);
   import wlfs_pkg::*;

   back_state_type state_ff, state_in;

   logic [2:0]        idx_ff, idx_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [SLOW_W-1:0] lacc_ff, lacc_in, racc_ff, racc_in;
   logic              allw_ff, allw_in;
   logic              lo_white_ff, lo_white_in, lo_black_ff, lo_black_in;
   logic              ro_white_ff, ro_white_in, ro_black_ff, ro_black_in;
   logic [MULT_W-1:0] ml_ff, ml_in, mr_ff, mr_in, big_ff, big_in;
   logic              left_big_ff, left_big_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [7:0]        ldrv_ff, ldrv_in, rdrv_ff, rdrv_in;
   logic              lrev_ff, lrev_in, rrev_ff, rrev_in;

   logic              on_black_ff, on_black_in;
   logic              ltl_ff, ltl_in;
   logic [1:0]        count_ff, count_in;
   logic              halted_ff, halted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;

   logic [RAW_W-1:0]  raw;
   logic [7:0]        weight;
   logic [16:0]       prod;
   logic              is_white;
   logic [MULT_W:0]   mot_l, mot_r;

   // Slowdown to motor multiplier; the top bit is the reverse flag.
   function automatic logic [MULT_W:0] motor_mult(input logic [SLOW_W-1:0] slow);
      logic [SLOW_W-1:0] red;
      logic              rev;
      rev = (slow > PCT_ONE);
      red = rev ? slow - PCT_ONE : slow;
      if (red >= PCT_ONE) begin
         motor_mult = {rev, {MULT_W{1'b0}}};
      end else begin
         motor_mult = {rev, MULT_W'(PCT_ONE - red)};
      end
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   assign raw      = RAW_W'(q_raw[idx_ff]);
   assign prod     = lvl_ff * weight;
   assign is_white = (lvl_ff < cfg.white_level);
   assign mot_l    = motor_mult(lacc_ff);
   assign mot_r    = motor_mult(racc_ff);

   always_comb begin
      case (idx_ff)
         SLOT_LEFT_OUTER, SLOT_RIGHT_OUTER:   weight = cfg.outer_weight;
         SLOT_LEFT_MIDDLE, SLOT_RIGHT_MIDDLE: weight = cfg.middle_weight;
         default:                             weight = cfg.inner_weight;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      lacc_in      = lacc_ff;
      racc_in      = racc_ff;
      allw_in      = allw_ff;
      lo_white_in  = lo_white_ff;
      lo_black_in  = lo_black_ff;
      ro_white_in  = ro_white_ff;
      ro_black_in  = ro_black_ff;
      ml_in        = ml_ff;
      mr_in        = mr_ff;
      big_in       = big_ff;
      left_big_in  = left_big_ff;
      num_in       = num_ff;
      ldrv_in      = ldrv_ff;
      rdrv_in      = rdrv_ff;
      lrev_in      = lrev_ff;
      rrev_in      = rrev_ff;
      on_black_in  = on_black_ff;
      ltl_in       = ltl_ff;
      count_in     = count_ff;
      halted_in    = halted_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      div_req      = '0;

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               idx_in   = '0;
               lacc_in  = '0;
               racc_in  = '0;
               allw_in  = 1'b1;
               state_in = B_SCALE;
            end
         end
         B_SCALE: begin
            if (raw <= cfg.raw_floor) begin
               lvl_in   = '0;
               state_in = B_ACC;
            end else if (cfg.raw_ceiling <= cfg.raw_floor || raw >= cfg.raw_ceiling) begin
               lvl_in   = FULL_LEVEL;
               state_in = B_ACC;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {raw - cfg.raw_floor, 8'h00};
               div_req.den   = cfg.raw_ceiling - cfg.raw_floor;
               state_in      = B_DIV;
            end
         end
         B_DIV: begin
            if (div_rsp.done) begin
               lvl_in   = LVL_W'(div_rsp.quo);
               state_in = B_ACC;
            end
         end
         B_ACC: begin
            if (idx_ff <= SLOT_LEFT_INNER) begin
               lacc_in = lacc_ff + SLOW_W'(prod);
            end else begin
               racc_in = racc_ff + SLOW_W'(prod);
            end
            allw_in = allw_ff && is_white;
            if (idx_ff == SLOT_LEFT_OUTER) begin
               lo_white_in = is_white;
               lo_black_in = (lvl_ff > cfg.black_level);
            end
            if (idx_ff == SLOT_RIGHT_OUTER) begin
               ro_white_in = is_white;
               ro_black_in = (lvl_ff > cfg.black_level);
               state_in    = B_MOTOR;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = B_SCALE;
            end
         end
         B_MOTOR: begin
            ml_in = mot_l[MULT_W-1:0];
            mr_in = mot_r[MULT_W-1:0];
            if (on_black_ff) begin
               ldrv_in  = 8'd255;
               rdrv_in  = 8'd255;
               lrev_in  = 1'b0;
               rrev_in  = 1'b0;
               state_in = B_DONE;
            end else if (allw_ff) begin
               // Everything white: pivot on the stopped wheel toward the last turn.
               lrev_in  = !ltl_ff;
               rrev_in  = ltl_ff;
               ldrv_in  = ltl_ff ? 8'd0 : cfg.drive_speed;
               rdrv_in  = ltl_ff ? cfg.drive_speed : 8'd0;
               state_in = B_DONE;
            end else begin
               lrev_in  = mot_l[MULT_W];
               rrev_in  = mot_r[MULT_W];
               state_in = B_PROD;
            end
         end
         B_PROD: begin
            left_big_in = (ml_ff > mr_ff);
            big_in      = left_big_in ? ml_ff : mr_ff;
            num_in      = DIV_NUM_W'(cfg.drive_speed * (left_big_in ? mr_ff : ml_ff));
            if (big_in == '0) begin
               ldrv_in  = 8'd0;
               rdrv_in  = cfg.drive_speed;
               ltl_in   = 1'b0;
               state_in = B_DONE;
            end else begin
               state_in = B_RATIO;
            end
         end
         B_RATIO: begin
            div_req.start = 1'b1;
            div_req.num   = num_ff;
            div_req.den   = DIV_DEN_W'(big_ff);
            state_in      = B_RWAIT;
         end
         B_RWAIT: begin
            if (div_rsp.done) begin
               if (left_big_ff) begin
                  ldrv_in = cfg.drive_speed;
                  rdrv_in = div_rsp.quo[7:0];
               end else begin
                  ldrv_in = div_rsp.quo[7:0];
                  rdrv_in = cfg.drive_speed;
               end
               ltl_in   = left_big_ff;
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (on_black_ff) begin
                  if (ro_white_ff && lo_white_ff) begin
                     on_black_in = 1'b0;
                  end
               end else if (ro_black_ff && lo_black_ff) begin
                  if (count_ff != 2'd3) begin
                     count_in = count_ff + 2'd1;
                  end
                  on_black_in = 1'b1;
               end
               if (count_in == 2'(STOP_CROSSINGS)) begin
                  halted_in = 1'b1;
               end
               result_in.left_drive    = ldrv_ff;
               result_in.right_drive   = rdrv_ff;
               result_in.left_reverse  = lrev_ff;
               result_in.right_reverse = rrev_ff;
               result_in.motors_halted = halted_in;
               result_in.over_line     = on_black_in;
               result_in.crossings     = count_in;
               rsp_valid_in            = 1'b1;
               pop                     = 1'b1;
               state_in                = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         on_black_ff  <= 1'b1;
         ltl_ff       <= 1'b1;
         count_ff     <= 2'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         on_black_ff  <= on_black_in;
         ltl_ff       <= ltl_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lvl_ff      <= lvl_in;
      lacc_ff     <= lacc_in;
      racc_ff     <= racc_in;
      allw_ff     <= allw_in;
      lo_white_ff <= lo_white_in;
      lo_black_ff <= lo_black_in;
      ro_white_ff <= ro_white_in;
      ro_black_ff <= ro_black_in;
      ml_ff       <= ml_in;
      mr_ff       <= mr_in;
      big_ff      <= big_in;
      left_big_ff <= left_big_in;
      num_ff      <= num_in;
      ldrv_ff     <= ldrv_in;
      rdrv_ff     <= rdrv_in;
      lrev_ff     <= lrev_in;
      rrev_ff     <= rrev_in;
      result_ff   <= result_in;
   end

endmodule

`default_nettype wire

>>> rtl/weighted_line_follow_steer.sv
// Channel  Ports   Direction  Contents
// req      req_*   in         one sweep of six raw sensor readings
// rsp      rsp_*   out        motor drives, directions and line status
// csr      csr_*   in         register writes, no read-back
//
// An item runs one divide for each sensor whose reading is not clamped, plus
// one for the steering ratio while following the line; the shared 9-step
// divider serves every divide.
// A two-beat queue takes new sweeps while the back end works, and a result
// register holds a finished beat while rsp_ready is low.
// Reset is synchronous and restores the control registers, configuration and steering state.
`default_nettype none

module weighted_line_follow_steer #(
   parameter int SENSOR_BITS    = wlfs_pkg::SENSOR_BITS_DEF,
   parameter int STOP_CROSSINGS = wlfs_pkg::STOP_CROSSINGS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_left_outer_raw,
   input  logic [15:0]                      req_left_middle_raw,
   input  logic [15:0]                      req_left_inner_raw,
   input  logic [15:0]                      req_right_inner_raw,
   input  logic [15:0]                      req_right_middle_raw,
   input  logic [15:0]                      req_right_outer_raw,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_left_drive,
   output logic [7:0]                       rsp_right_drive,
   output logic                             rsp_left_reverse,
   output logic                             rsp_right_reverse,
   output logic                             rsp_motors_halted,
   output logic                             rsp_over_line,
   output logic [1:0]                       rsp_crossings,
   input  logic                             csr_wen,
   input  logic [wlfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wlfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wlfs_pkg::*;

   cfg_type     cfg_ff;
   logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0] req_raw, q_raw;
   logic        q_valid, pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  result;

   assign req_raw[SLOT_LEFT_OUTER]   = req_left_outer_raw[SENSOR_BITS-1:0];
   assign req_raw[SLOT_LEFT_MIDDLE]  = req_left_middle_raw[SENSOR_BITS-1:0];
   assign req_raw[SLOT_LEFT_INNER]   = req_left_inner_raw[SENSOR_BITS-1:0];
   assign req_raw[SLOT_RIGHT_INNER]  = req_right_inner_raw[SENSOR_BITS-1:0];
   assign req_raw[SLOT_RIGHT_MIDDLE] = req_right_middle_raw[SENSOR_BITS-1:0];
   assign req_raw[SLOT_RIGHT_OUTER]  = req_right_outer_raw[SENSOR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_speed   <= 8'd255;
         cfg_ff.raw_floor     <= 16'd3750;
         cfg_ff.raw_ceiling   <= 16'd24250;
         cfg_ff.white_level   <= 9'd77;
         cfg_ff.black_level   <= 9'd179;
         cfg_ff.inner_weight  <= 8'd25;
         cfg_ff.middle_weight <= 8'd50;
         cfg_ff.outer_weight  <= 8'd100;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DRIVE_SPEED:   cfg_ff.drive_speed   <= csr_wdata[7:0];
            CSR_RAW_FLOOR:     cfg_ff.raw_floor     <= csr_wdata;
            CSR_RAW_CEILING:   cfg_ff.raw_ceiling   <= csr_wdata;
            CSR_WHITE_LEVEL:   cfg_ff.white_level   <= csr_wdata[LVL_W-1:0];
            CSR_BLACK_LEVEL:   cfg_ff.black_level   <= csr_wdata[LVL_W-1:0];
            CSR_INNER_WEIGHT:  cfg_ff.inner_weight  <= csr_wdata[7:0];
            CSR_MIDDLE_WEIGHT: cfg_ff.middle_weight <= csr_wdata[7:0];
            CSR_OUTER_WEIGHT:  cfg_ff.outer_weight  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   wlfs_front #(
      .SENSOR_BITS(SENSOR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_raw   (req_raw),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_raw     (q_raw)
   );

   wlfs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   wlfs_back #(
      .SENSOR_BITS    (SENSOR_BITS),
      .STOP_CROSSINGS (STOP_CROSSINGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_raw     (q_raw),
      .pop       (pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_left_drive    = result.left_drive;
   assign rsp_right_drive   = result.right_drive;
   assign rsp_left_reverse  = result.left_reverse;
   assign rsp_right_reverse = result.right_reverse;
   assign rsp_motors_halted = result.motors_halted;
   assign rsp_over_line     = result.over_line;
   assign rsp_crossings     = result.crossings;

endmodule

`default_nettype wire

>>> rtl/wlfs_check.sv
`default_nettype none

module wlfs_check #(
   parameter int STOP_CROSSINGS = wlfs_pkg::STOP_CROSSINGS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_left_drive,
   input logic [7:0] rsp_right_drive,
   input logic       rsp_motors_halted,
   input logic [1:0] rsp_crossings
);
   logic seen_halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_motors_halted) begin
         seen_halt_ff <= 1'b1;
      end
   end

   // A beat held back by the sink stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive))
      else $error("rsp beat changed while stalled");

   // The halt flag is sticky across delivered beats.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_halt_ff |-> rsp_motors_halted)
      else $error("halt flag dropped");

   // Halting and the crossing count agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motors_halted |-> rsp_crossings >= 2'(STOP_CROSSINGS))
      else $error("halted before the stop crossing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crossings == 2'(STOP_CROSSINGS) |-> rsp_motors_halted)
      else $error("stop crossing reached without halt");

endmodule

bind weighted_line_follow_steer wlfs_check #(
   .STOP_CROSSINGS(STOP_CROSSINGS)
) u_wlfs_check (.*);

`default_nettype wire
